### src/dep_pkg.sv
// Package for the directory entry parser: item types and record layout constants.
// Used by dep_parse, dep_out_buf and directory_entry_parser; no dependencies.
`default_nettype none

package dep_pkg;

  localparam int unsigned HdrBytes      = 8;
  localparam int unsigned NameLenOffset = 6;
  localparam int unsigned LenLoOffset   = 4;
  localparam int unsigned LenHiOffset   = 5;
  localparam int unsigned TypeOffset    = 7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       dir_end;
  } in_t;

  typedef struct packed {
    logic [31:0] entry_inode;
    logic [7:0]  name_char;
    logic [7:0]  char_index;
    logic        has_char;
    logic        name_end;
    logic        bad_record;
  } out_t;

endpackage

`default_nettype wire

### src/dep_parse.sv
// Record parser: tracks the position inside a directory record and forms one result item.
// Depends on dep_pkg for the item types and header offsets.
`default_nettype none

module dep_parse import dep_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic acc_i,
  input  wire in_t  in_i,
  output logic      res_valid_o,
  output out_t      res_o
);

  logic [15:0] record_pos_q, record_pos_d;
  logic [15:0] record_len_q, record_len_d;
  logic [31:0] held_inode_q, held_inode_d;
  logic [7:0]  held_name_len_q, held_name_len_d;
  logic        halted_q, halted_d;

  logic [16:0] pos_inc;
  logic [15:0] name_idx;
  logic [8:0]  min_len;
  logic        advance;

  assign pos_inc  = {1'b0, record_pos_q} + 17'd1;
  assign name_idx = record_pos_q - 16'(HdrBytes);
  assign min_len  = 9'(HdrBytes) + {1'b0, held_name_len_q};

  always_comb begin
    record_pos_d    = record_pos_q;
    record_len_d    = record_len_q;
    held_inode_d    = held_inode_q;
    held_name_len_d = held_name_len_q;
    halted_d        = halted_q;
    advance         = 1'b0;
    res_valid_o     = 1'b0;
    res_o           = '0;
    res_o.entry_inode = held_inode_q;

    if (acc_i && !halted_q) begin
      advance = 1'b1;
      if (record_pos_q < 16'(LenLoOffset)) begin
        case (record_pos_q[1:0])
          2'd0:    held_inode_d[7:0]   = in_i.data_byte;
          2'd1:    held_inode_d[15:8]  = in_i.data_byte;
          2'd2:    held_inode_d[23:16] = in_i.data_byte;
          2'd3:    held_inode_d[31:24] = in_i.data_byte;
          default: held_inode_d        = held_inode_q;
        endcase
      end else if (record_pos_q == 16'(LenLoOffset)) begin
        record_len_d[7:0] = in_i.data_byte;
      end else if (record_pos_q == 16'(LenHiOffset)) begin
        record_len_d[15:8] = in_i.data_byte;
      end else if (record_pos_q == 16'(NameLenOffset)) begin
        held_name_len_d = in_i.data_byte;
      end else if (record_pos_q == 16'(TypeOffset)) begin
        // The whole header is known on the type byte, so the length check happens here.
        if (record_len_q < {7'd0, min_len}) begin
          res_valid_o      = 1'b1;
          res_o.bad_record = 1'b1;
          halted_d         = 1'b1;
          advance          = 1'b0;
        end else if (held_inode_q != '0 && held_name_len_q == '0) begin
          res_valid_o    = 1'b1;
          res_o.name_end = 1'b1;
        end
      end else begin
        if (held_inode_q != '0 && name_idx < {8'd0, held_name_len_q}) begin
          res_valid_o      = 1'b1;
          res_o.name_char  = in_i.data_byte;
          res_o.char_index = name_idx[7:0];
          res_o.has_char   = 1'b1;
          res_o.name_end   = (name_idx[7:0] + 8'd1 == held_name_len_q);
        end
      end

      if (advance) begin
        if (pos_inc >= 17'(HdrBytes) && pos_inc >= {1'b0, record_len_q}) begin
          record_pos_d = '0;
        end else begin
          record_pos_d = pos_inc[15:0];
        end
      end
    end

    if (acc_i && in_i.dir_end) begin
      record_pos_d    = '0;
      record_len_d    = '0;
      held_inode_d    = '0;
      held_name_len_d = '0;
      halted_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_pos_q    <= '0;
      record_len_q    <= '0;
      held_inode_q    <= '0;
      held_name_len_q <= '0;
      halted_q        <= 1'b0;
    end else begin
      record_pos_q    <= record_pos_d;
      record_len_q    <= record_len_d;
      held_inode_q    <= held_inode_d;
      held_name_len_q <= held_name_len_d;
      halted_q        <= halted_d;
    end
  end

  a_halt_holds_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q && !(acc_i && in_i.dir_end) |=> $stable(record_pos_q))
    else $error("record position moved while halted");

  a_bad_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.bad_record && !in_i.dir_end |=> halted_q)
    else $error("bad record did not halt the parser");

  a_pos_in_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !halted_q && record_pos_q >= 16'(HdrBytes) |-> record_pos_q < record_len_q)
    else $error("record position ran past the record length");

endmodule

`default_nettype wire

### src/dep_out_buf.sv
// Two-entry result buffer that decouples the parser from a stalled output.
// Depends on dep_pkg for the result item type.
`default_nettype none

module dep_out_buf import dep_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire out_t push_data_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic stall_i,
  output out_t      data_o
);

  out_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign push    = push_i && !full_o;
  assign pop     = valid_o && !stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer count out of range");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("result item pushed into a full buffer");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> count_q == $past(count_q) - 2'd1)
    else $error("result buffer count did not drop on a pop");

endmodule

`default_nettype wire

### src/directory_entry_parser.sv
// Each result item is written into the two-entry result buffer and driven onto the output from there.
// Throughput: one input byte per cycle; the two-entry result buffer keeps input flowing
// while one result waits, and input stalls only when both entries are occupied.
// Reset (asynchronous, active low) returns the parser to the start of a record, unhalted,
// and empties the result buffer.
// Top level of the directory entry parser; instantiates dep_parse and dep_out_buf.
`default_nettype none

module directory_entry_parser import dep_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic accept;
  logic res_valid;
  out_t res;
  logic buf_full;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  dep_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (accept),
    .in_i       (in_data_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  dep_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .full_o     (buf_full),
    .valid_o    (out_valid_o),
    .stall_i    (out_stall_i),
    .data_o     (out_data_o)
  );

endmodule

`default_nettype wire
